[design/nbe_pkg.sv]
// Shared types and constants for the nested block extractor.
`timescale 1ns / 1ps
package nbe_pkg;

    localparam int DEPTH_BITS = 16;
    localparam logic [DEPTH_BITS-1:0] DEPTH_ONE = DEPTH_BITS'(1);
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

    // character codes
    localparam logic [7:0] CH_END    = 8'h00;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;

    // scan modes
    localparam logic [2:0] MODE_NORMAL = 3'd0;
    localparam logic [2:0] MODE_SQ     = 3'd1;
    localparam logic [2:0] MODE_DQ     = 3'd2;
    localparam logic [2:0] MODE_BLOCK  = 3'd3;
    localparam logic [2:0] MODE_STAR   = 3'd4;
    localparam logic [2:0] MODE_SLASH  = 3'd5;
    localparam logic [2:0] MODE_LINE   = 3'd6;

    // result status
    localparam logic [1:0] ST_SCAN     = 2'd0;
    localparam logic [1:0] ST_DONE     = 2'd1;
    localparam logic [1:0] ST_UNTERM   = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_OPEN  = 2'd0;
    localparam logic [1:0] CFG_CLOSE = 2'd1;
    localparam logic [1:0] CFG_LINE  = 2'd2;

    // results per input beat
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] open_code;
        logic [7:0] close_char;
        logic       line_comments_on;
    } t_cfg;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_valid;
        logic [1:0] status;
        logic       last;
    } t_res;

    typedef struct packed {
        logic [1:0] count;
        t_res       res0;
        t_res       res1;
    } t_scan_out;

endpackage

[design/nbe_scan.sv]
// Scan state (mode and depth) and the per-character decision logic.
`timescale 1ns / 1ps
module nbe_scan
    import nbe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_char,
    input  t_cfg       i_cfg,
    output t_scan_out  o_scan
);

    logic [2:0]            r_mode;
    logic [DEPTH_BITS-1:0] r_depth;
    logic [2:0]            n_mode;
    logic [DEPTH_BITS-1:0] n_depth;
    logic                  do_norm;
    t_scan_out             scan;

    always_comb begin
        n_mode  = r_mode;
        n_depth = r_depth;
        do_norm = 1'b0;
        scan    = '0;
        if (i_char == CH_END) begin
            n_mode     = MODE_NORMAL;
            n_depth    = DEPTH_ONE;
            scan.count = CNT_ONE;
            scan.res0  = '{out_char: 8'h00, out_valid: 1'b0, status: ST_UNTERM, last: 1'b1};
        end else begin
            case (r_mode)
                MODE_BLOCK: begin
                    if (i_char == CH_STAR) n_mode = MODE_STAR;
                end
                MODE_STAR: begin
                    n_mode = (i_char == CH_SLASH) ? MODE_NORMAL : MODE_BLOCK;
                end
                MODE_SQ, MODE_DQ: begin
                    if ((r_mode == MODE_SQ && i_char == CH_SQUOTE) ||
                        (r_mode == MODE_DQ && i_char == CH_DQUOTE)) n_mode = MODE_NORMAL;
                    scan.count = CNT_ONE;
                    scan.res0  = '{out_char: i_char, out_valid: 1'b1, status: ST_SCAN,
                                   last: 1'b1};
                end
                MODE_SLASH: begin
                    if (i_char == CH_STAR) begin
                        n_mode = MODE_BLOCK;
                    end else if (i_cfg.line_comments_on && i_char == CH_SLASH) begin
                        n_mode = MODE_LINE;
                    end else begin
                        // lone slash: emit it, then the next character verbatim
                        n_mode     = MODE_NORMAL;
                        scan.count = CNT_TWO;
                        scan.res0  = '{out_char: CH_SLASH, out_valid: 1'b1, status: ST_SCAN,
                                       last: 1'b0};
                        scan.res1  = '{out_char: i_char, out_valid: 1'b1, status: ST_SCAN,
                                       last: 1'b1};
                    end
                end
                MODE_LINE: begin
                    if (i_char == CH_NL) begin
                        n_mode  = MODE_NORMAL;
                        do_norm = 1'b1;
                    end
                end
                MODE_NORMAL: begin
                    do_norm = 1'b1;
                end
                default: begin
                    n_mode  = MODE_NORMAL;
                    do_norm = 1'b1;
                end
            endcase

            if (do_norm) begin
                scan.count = CNT_ONE;
                scan.res0  = '{out_char: i_char, out_valid: 1'b1, status: ST_SCAN, last: 1'b1};
                if (i_char == i_cfg.close_char) begin
                    if (r_depth <= DEPTH_ONE) begin
                        n_mode    = MODE_NORMAL;
                        n_depth   = DEPTH_ONE;
                        scan.res0 = '{out_char: 8'h00, out_valid: 1'b0, status: ST_DONE,
                                      last: 1'b1};
                    end else begin
                        n_depth = r_depth - DEPTH_ONE;
                    end
                end else if (i_char == i_cfg.open_code) begin
                    if (r_depth == DEPTH_MAX) begin
                        n_mode    = MODE_NORMAL;
                        n_depth   = DEPTH_ONE;
                        scan.res0 = '{out_char: 8'h00, out_valid: 1'b0, status: ST_OVERFLOW,
                                      last: 1'b1};
                    end else begin
                        n_depth = r_depth + DEPTH_ONE;
                    end
                end else if (i_char == CH_SLASH) begin
                    n_mode     = MODE_SLASH;
                    scan.count = CNT_NONE;
                    scan.res0  = '0;
                end else if (i_char == CH_SQUOTE) begin
                    n_mode = MODE_SQ;
                end else if (i_char == CH_DQUOTE) begin
                    n_mode = MODE_DQ;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_NORMAL;
            r_depth <= DEPTH_ONE;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_depth <= n_depth;
        end
    end

    assign o_scan = scan;

endmodule

[design/nbe_outq.sv]
// Result queue: takes up to two results per cycle, hands out one per beat.
`timescale 1ns / 1ps
module nbe_outq
    import nbe_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_scan_out i_scan,
    output logic      o_room,
    output logic      o_valid,
    input  logic      i_ready,
    output t_res      o_res
);

    t_res                 r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr;
    logic [QPTR_BITS-1:0] r_rd;
    logic [QCNT_BITS-1:0] r_cnt;
    logic [QPTR_BITS-1:0] n_wr;
    logic [QCNT_BITS-1:0] n_cnt;
    logic [QCNT_BITS-1:0] push_n;
    logic                 pop;

    assign pop    = o_valid && i_ready;
    assign push_n = i_push ? QCNT_BITS'(i_scan.count) : '0;
    assign n_wr   = r_wr + QPTR_BITS'(push_n);
    assign n_cnt  = r_cnt + push_n - QCNT_BITS'(pop);

    always_ff @(posedge i_clk) begin
        if (i_push && i_scan.count != CNT_NONE) r_mem[r_wr] <= i_scan.res0;
        if (i_push && i_scan.count == CNT_TWO) r_mem[r_wr + QPTR_BITS'(1)] <= i_scan.res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_cnt <= n_cnt;
            if (pop) r_rd <= r_rd + QPTR_BITS'(1);
        end
    end

    // room for the worst case of two results
    assign o_room  = r_cnt <= QCNT_BITS'(QUEUE_DEPTH - 2);
    assign o_valid = r_cnt != '0;
    assign o_res   = r_mem[r_rd];

endmodule

[design/nested_block_extractor.sv]
// Top level of the nested block extractor: config registers, scanner, result queue.
`timescale 1ns / 1ps
//
//  channel   handshake              payload                              dir
//  -------   ---------------------  -----------------------------------  ---
//  input     i_valid / o_ready      i_char_in                            in
//  result    o_valid / i_ready      o_out_char o_out_valid o_status      out
//                                   o_last
//  config    i_cfg_valid /          i_cfg_index i_cfg_data               in
//            o_cfg_ready
//
//  One character is taken per cycle while the queue has room. Each beat is
//  decided in the cycle it is accepted and its results are registered into
//  a four-entry result queue; a lone slash yields two results on the
//  following character.
//  Input ready drops while three or more results wait in the queue, so a
//  stalled result side stops intake after three result-bearing beats (two
//  when a slash pair lands); beats that give no result add nothing to the queue.
//  Reset (synchronous, active low) sets depth 1, normal mode, empty queue
//  and the register defaults: open 123, close 125, line comments off.
//  Config beats are always taken; index 3 is ignored.
module nested_block_extractor
    import nbe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // character input
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_in,
    // results
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_char,
    output logic       o_out_valid,
    output logic [1:0] o_status,
    output logic       o_last,
    // configuration
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    t_cfg      r_cfg;
    t_scan_out scan;
    t_res      res;
    logic      room;
    logic      accept;

    // Config registers: to be written only while idle, so no hazard with scanning; the block does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.open_code        <= 8'd123;
            r_cfg.close_char       <= 8'd125;
            r_cfg.line_comments_on <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_OPEN:  r_cfg.open_code        <= i_cfg_data;
                CFG_CLOSE: r_cfg.close_char       <= i_cfg_data;
                CFG_LINE:  r_cfg.line_comments_on <= i_cfg_data[0];
                default:   ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_ready     = room;
    assign accept      = i_valid && room;

    nbe_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_char   (i_char_in),
        .i_cfg    (r_cfg),
        .o_scan   (scan)
    );

    nbe_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_scan  (scan),
        .o_room  (room),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (res)
    );

    assign o_out_char  = res.out_char;
    assign o_out_valid = res.out_valid;
    assign o_status    = res.status;
    assign o_last      = res.last;

endmodule

[design/nbe_checker.sv]
// Port-level checks for the nested block extractor, bound to the top level.
`timescale 1ns / 1ps
module nbe_port_checks
    import nbe_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_out_char,
    input logic       o_out_valid,
    input logic [1:0] o_status,
    input logic       o_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_char) && $stable(o_status)
            && $stable(o_last) && $stable(o_out_valid))
        else $error("result changed while stalled");

    a_event_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_SCAN |-> !o_out_valid && o_out_char == 8'h00 && o_last)
        else $error("event result malformed");

    a_scan_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_SCAN |-> o_out_valid)
        else $error("scan result without character");

    a_first_of_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_out_char == CH_SLASH && o_status == ST_SCAN)
        else $error("non-final result is not a slash");

    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last |=> o_valid && o_out_valid && o_status == ST_SCAN)
        else $error("second result of slash pair missing");

endmodule

bind nested_block_extractor nbe_port_checks u_nbe_port_checks (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_out_char  (o_out_char),
    .o_out_valid (o_out_valid),
    .o_status    (o_status),
    .o_last      (o_last)
);
